// File: rtl/scharr_abs_gradient_3x3_macros.svh
// Assertion macros for the Scharr gradient checker.
`ifndef SCHARR_ABS_GRADIENT_3X3_MACROS_SVH
`define SCHARR_ABS_GRADIENT_3X3_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCHARR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCHARR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scharr_pkg.sv
// Shared constants, widths and register indexes of the Scharr gradient block.
package scharr_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int PIXEL_W     = 8;
    localparam int GRAD_W      = 12;
    localparam int ROW_W       = 12;
    localparam int COL_OUT_W   = 10;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

// File: rtl/scharr_stream_if.sv
// Valid/ready stream interfaces for pixel words and gradient result words.
interface scharr_pix_if;
    logic                             valid;
    logic                             ready;
    logic [scharr_pkg::PIXEL_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface scharr_res_if;
    logic                             valid;
    logic                             ready;
    logic [scharr_pkg::GRAD_W-1:0]    grad_x;
    logic [scharr_pkg::GRAD_W-1:0]    grad_y;
    logic [scharr_pkg::ROW_W-1:0]     center_row;
    logic [scharr_pkg::COL_OUT_W-1:0] center_col;
    logic                             last_of_frame;

    modport source (output valid, output grad_x, output grad_y, output center_row,
                    output center_col, output last_of_frame, input ready);
    modport sink   (input valid, input grad_x, input grad_y, input center_row,
                    input center_col, input last_of_frame, output ready);
endinterface

// File: rtl/scharr_ram.sv
// Generic simple dual-port RAM, one write port, one read port, registered read.
module scharr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/scharr_abs_gradient_3x3.sv
// Top level: absolute 3x3 Scharr gradients over a raster pixel stream.
// Takes one 8-bit pixel word per clock in raster order unless a waiting result stalls it.
// The two line buffers share one MAX_WIDTH x 16 RAM that is read at the pixel's column
// when the word is accepted and written back as it leaves stage 1, so each pixel costs
// one read and one write. An interior center's result word is registered as the pixel
// below and right of it leaves stage 1; border pixels give no word. The pixel side keeps
// accepting while a result waits, as long as the one stage between the RAM and the
// output register is free. Line buffer contents are undefined until the first rows of
// an image have passed; there is no clearing pass after reset. The user must write image
// width and height through the cfg port only while idle; the block does not enforce it.
module scharr_abs_gradient_3x3 #(
    parameter int MAX_WIDTH = scharr_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scharr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [scharr_pkg::CFG_DATA_W-1:0]   cfg_data,
    scharr_pix_if.sink                          pix,
    scharr_res_if.source                        res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > scharr_pkg::CFG_WIDTH_W) ? CW + 1 : scharr_pkg::CFG_WIDTH_W;
    localparam int PW = scharr_pkg::PIXEL_W;
    localparam int RW = scharr_pkg::ROW_W;
    localparam int HW = scharr_pkg::CFG_HEIGHT_W;
    localparam logic [WW-1:0] MAX_W_C = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MIN_W_C = WW'(3);
    localparam logic [HW-1:0] MIN_H_C = HW'(3);

    function automatic logic [scharr_pkg::GRAD_W-1:0] abs_scharr(
        input logic [PW-1:0] p0, input logic [PW-1:0] n0,
        input logic [PW-1:0] p1, input logic [PW-1:0] n1,
        input logic [PW-1:0] p2, input logic [PW-1:0] n2
    );
        logic signed [13:0] s;
        s = 14'sd3  * ($signed({6'd0, p0}) - $signed({6'd0, n0}))
          + 14'sd10 * ($signed({6'd0, p1}) - $signed({6'd0, n1}))
          + 14'sd3  * ($signed({6'd0, p2}) - $signed({6'd0, n2}));
        return s[13] ? scharr_pkg::GRAD_W'(-s) : scharr_pkg::GRAD_W'(s);
    endfunction

    // configuration
    logic [scharr_pkg::CFG_WIDTH_W-1:0] width_reg;
    logic [HW-1:0]                      height_reg;
    logic [WW-1:0]                      eff_w;
    logic [HW-1:0]                      eff_h;

    // position counters
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          wrap_c;
    logic [RW:0]   row_inc;
    logic [RW-1:0] r_cur;
    logic [CW-1:0] c_cur;
    logic [WW-1:0] c_inc;
    logic          col_end;
    logic [RW:0]   row_step;
    logic          emit;
    logic          last;

    // stage 1: RAM read in flight
    logic                          s1_valid_reg;
    logic [PW-1:0]                 s1_pixel_reg;
    logic [CW-1:0]                 s1_addr_reg;
    logic                          s1_emit_reg;
    logic                          s1_last_reg;
    logic [RW-1:0]                 s1_row_reg;
    logic [scharr_pkg::COL_OUT_W-1:0] s1_col_reg;
    logic                          s1_adv;
    logic                          accept;

    logic [2*PW-1:0] ram_rdata;
    logic [PW-1:0]   top_px;
    logic [PW-1:0]   mid_px;

    logic [PW-1:0] win_reg  [3][3];
    logic [PW-1:0] win_next [3][3];

    // output register
    logic                             out_valid_reg;
    logic [scharr_pkg::GRAD_W-1:0]    gx_reg;
    logic [scharr_pkg::GRAD_W-1:0]    gy_reg;
    logic [RW-1:0]                    orow_reg;
    logic [scharr_pkg::COL_OUT_W-1:0] ocol_reg;
    logic                             olast_reg;

    always_comb
    begin
        eff_w = WW'(width_reg);
        if (eff_w < MIN_W_C)
        begin
            eff_w = MIN_W_C;
        end
        else if (eff_w > MAX_W_C)
        begin
            eff_w = MAX_W_C;
        end
        eff_h = (height_reg < MIN_H_C) ? MIN_H_C : height_reg;
    end

    always_comb
    begin
        wrap_c   = WW'(col_reg) >= eff_w;
        row_inc  = wrap_c ? {1'b0, row_reg} + 1'b1 : {1'b0, row_reg};
        r_cur    = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[RW-1:0];
        c_cur    = wrap_c ? '0 : col_reg;
        c_inc    = WW'(c_cur) + 1'b1;
        col_end  = c_inc >= eff_w;
        col_next = col_end ? '0 : c_inc[CW-1:0];
        row_step = {1'b0, r_cur} + 1'b1;
        if (col_end)
        begin
            row_next = (row_step >= {1'b0, eff_h}) ? '0 : row_step[RW-1:0];
        end
        else
        begin
            row_next = r_cur;
        end
        emit = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
        last = (r_cur == RW'(eff_h - 1'b1)) && col_end;
    end

    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || res.ready);
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign accept    = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= scharr_pkg::WIDTH_RESET;
            height_reg <= scharr_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                scharr_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[scharr_pkg::CFG_WIDTH_W-1:0];
                end
                scharr_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[HW-1:0];
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pix.pixel;
            s1_addr_reg  <= c_cur;
            s1_emit_reg  <= emit;
            s1_last_reg  <= last;
            s1_row_reg   <= r_cur - 1'b1;
            s1_col_reg   <= scharr_pkg::COL_OUT_W'(c_cur - 1'b1);
        end
    end

    // line buffers: upper in the high byte, middle in the low byte
    scharr_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr_reg),
        .wdata ({mid_px, s1_pixel_reg}),
        .re    (accept),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    assign top_px = ram_rdata[2*PW-1:PW];
    assign mid_px = ram_rdata[PW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit_reg)
        begin
            gx_reg    <= abs_scharr(win_next[0][2], win_next[0][0],
                                    win_next[1][2], win_next[1][0],
                                    win_next[2][2], win_next[2][0]);
            gy_reg    <= abs_scharr(win_next[2][0], win_next[0][0],
                                    win_next[2][1], win_next[0][1],
                                    win_next[2][2], win_next[0][2]);
            orow_reg  <= s1_row_reg;
            ocol_reg  <= s1_col_reg;
            olast_reg <= s1_last_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.grad_x        = gx_reg;
    assign res.grad_y        = gy_reg;
    assign res.center_row    = orow_reg;
    assign res.center_col    = ocol_reg;
    assign res.last_of_frame = olast_reg;

endmodule

// File: rtl/scharr_checker.sv
// Port-level checker for the Scharr gradient block, with its bind.
`include "scharr_abs_gradient_3x3_macros.svh"

module scharr_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [scharr_pkg::GRAD_W-1:0]        grad_x,
    input logic [scharr_pkg::GRAD_W-1:0]        grad_y,
    input logic [scharr_pkg::ROW_W-1:0]         center_row,
    input logic [scharr_pkg::COL_OUT_W-1:0]     center_col,
    input logic                                 last_of_frame
);

    // stalled result word holds
    `SCHARR_ASSERT_NXT(a_res_hold, out_valid && !out_ready, out_valid && $stable(grad_x) && $stable(grad_y) && $stable(center_row) && $stable(center_col) && $stable(last_of_frame), "result word changed while stalled")

    `SCHARR_ASSERT_IMP(a_res_range, out_valid, grad_x <= 12'd4080 && grad_y <= 12'd4080 && center_row != 12'd0, "gradient or row out of range")

    // next frame needs two rows before its first result
    `SCHARR_ASSERT_NXT(a_frame_gap, out_valid && out_ready && last_of_frame, !out_valid, "result right after end of frame")

    // back-to-back results inside a row step one column
    `SCHARR_ASSERT_IMP(a_col_step, (out_valid && out_ready) ##1 (out_valid && out_ready && center_col != 10'd1), center_col == 10'($past(center_col) + 10'd1), "column did not advance by one")

endmodule

bind scharr_abs_gradient_3x3 scharr_checker u_scharr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .grad_x        (res.grad_x),
    .grad_y        (res.grad_y),
    .center_row    (res.center_row),
    .center_col    (res.center_col),
    .last_of_frame (res.last_of_frame)
);

// File: dv/testbench.sv
// Self-checking testbench for the 3x3 Scharr absolute gradient block.
`timescale 1ns / 100ps

module testbench;

    localparam int LINE_MAX      = scharr_pkg::MAX_WIDTH_DEF;
    localparam int IDLE_PCT      = 15;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int END_LIMIT     = 2000;
    localparam int RANDOM_PIXELS = 650;

    typedef struct packed {
        logic [scharr_pkg::GRAD_W-1:0]    grad_x;
        logic [scharr_pkg::GRAD_W-1:0]    grad_y;
        logic [scharr_pkg::ROW_W-1:0]     center_row;
        logic [scharr_pkg::COL_OUT_W-1:0] center_col;
        logic                             last_of_frame;
    } grad_word_t;

    typedef struct packed {
        logic                              is_cfg;
        scharr_pkg::reg_idx_t              idx;
        logic [scharr_pkg::CFG_DATA_W-1:0] value;
        logic [scharr_pkg::PIXEL_W-1:0]    pixel;
        logic                              typed;
        grad_word_t                        word;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [scharr_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [scharr_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                              no_gaps;

    scharr_pix_if pix_bus ();
    scharr_res_if res_bus ();

    scharr_abs_gradient_3x3 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .pix      (pix_bus),
        .res      (res_bus)
    );

    // gradient predictor state
    logic [scharr_pkg::CFG_WIDTH_W-1:0]  width_reg  = scharr_pkg::WIDTH_RESET;
    logic [scharr_pkg::CFG_HEIGHT_W-1:0] height_reg = scharr_pkg::HEIGHT_RESET;
    bit [7:0]                lb_upper  [LINE_MAX];
    bit [7:0]                lb_middle [LINE_MAX];
    bit [1:0]                col_writes [LINE_MAX];
    bit [7:0]                win [3][3];
    int unsigned             row_pos;
    int unsigned             col_pos;

    grad_word_t  pending_gradients [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned fed_pixels;
    logic [7:0]  prev_pixel;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_reg < 3)
            return 3;
        if (width_reg > LINE_MAX)
            return LINE_MAX;
        return 32'(width_reg);
    endfunction

    function automatic int unsigned active_height();
        return (height_reg < 3) ? 3 : 32'(height_reg);
    endfunction

    function automatic bit predict_gradients(input logic [7:0] value, output grad_word_t word);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int          gx;
        int          gy;
        int          i;
        bit [7:0]    up;
        bit [7:0]    mid;
        w = active_width();
        h = active_height();
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        r = row_pos;
        c = col_pos;
        up  = lb_upper[c];
        mid = lb_middle[c];
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = value;
        lb_upper[c]  = mid;
        lb_middle[c] = value;
        if (col_writes[c] < 2)
            col_writes[c]++;
        word = '0;
        predict_gradients = (r >= 2 && c >= 2);
        if (predict_gradients)
        begin
            gx = 3 * (int'(win[0][2]) - int'(win[0][0]))
               + 10 * (int'(win[1][2]) - int'(win[1][0]))
               + 3 * (int'(win[2][2]) - int'(win[2][0]));
            gy = 3 * (int'(win[2][0]) - int'(win[0][0]))
               + 10 * (int'(win[2][1]) - int'(win[0][1]))
               + 3 * (int'(win[2][2]) - int'(win[0][2]));
            word.grad_x        = scharr_pkg::GRAD_W'((gx < 0) ? -gx : gx);
            word.grad_y        = scharr_pkg::GRAD_W'((gy < 0) ? -gy : gy);
            word.center_row    = scharr_pkg::ROW_W'(r - 1);
            word.center_col    = scharr_pkg::COL_OUT_W'(c - 1);
            word.last_of_frame = (r == h - 1) && (c == w - 1);
        end
        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic logic [7:0] next_pixel();
        case ($urandom_range(3))
            0: prev_pixel = 8'($urandom_range(255));
            1: prev_pixel = $urandom_range(1) ? 8'hFF : 8'h00;
            default: prev_pixel = prev_pixel + 8'($urandom_range(16)) - 8'd8;
        endcase
        return prev_pixel;
    endfunction

    function automatic stim_row_t cfg_row(input scharr_pkg::reg_idx_t idx,
                                          input logic [11:0] value);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        return row;
    endfunction

    function automatic stim_row_t pix_row(input logic [7:0] value);
        stim_row_t row;
        row       = '0;
        row.pixel = value;
        return row;
    endfunction

    function automatic stim_row_t checked_pix_row(input logic [7:0] value, input grad_word_t word);
        stim_row_t row;
        row       = pix_row(value);
        row.typed = 1'b1;
        row.word  = word;
        return row;
    endfunction

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s", $realtime, msg);
    endtask

    task automatic report_field(input string name, input logic [11:0] got,
                                input logic [11:0] want);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    endtask

    task automatic send_pixel(input logic [7:0] value, input bit typed,
                              input grad_word_t typed_word);
        grad_word_t predicted;
        bit         emitted;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            pix_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= value;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        emitted = predict_gradients(value, predicted);
        if (typed)
            pending_gradients.push_back(typed_word);
        else if (emitted)
            pending_gradients.push_back(predicted);
        fed_pixels++;
    endtask

    // border words give no result, so let the pipe empty before touching registers
    task automatic drain_results();
        pix_bus.valid <= 1'b0;
        while (pending_gradients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input scharr_pkg::reg_idx_t idx, input logic [11:0] value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == scharr_pkg::REG_IMAGE_WIDTH)
            width_reg = value[scharr_pkg::CFG_WIDTH_W-1:0];
        else
            height_reg = value[scharr_pkg::CFG_HEIGHT_W-1:0];
        @(posedge clk);
    endtask

    // phase 1 and 4: widest rows, cut back to three columns mid-image;
    // phase 3: tallest image, cut short mid-image
    task automatic run_phase(input int unsigned idx);
        logic [11:0] w_val;
        logic [11:0] h_val;
        int unsigned count;
        int unsigned split;
        int unsigned new_w;
        bit          safe;
        no_gaps <= (idx == 1);
        if (idx == 1 || idx == 4)
        begin
            w_val = (idx == 1) ? 12'd1024 : 12'hFFF;
            h_val = 12'd3;
        end
        else if (idx == 3)
        begin
            w_val = 12'd3;
            h_val = 12'd4095;
        end
        else
        begin
            w_val = ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                             : 12'($urandom_range(3, 14));
            h_val = ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                             : 12'($urandom_range(3, 7));
        end
        write_reg(scharr_pkg::REG_IMAGE_WIDTH, w_val);
        write_reg(scharr_pkg::REG_IMAGE_HEIGHT, h_val);
        if (idx == 3)
        begin
            count = 60;
            split = $urandom_range(30, 59);
        end
        else if (idx == 1 || idx == 4)
        begin
            count = $urandom_range(100, 200);
            split = count;
        end
        else
        begin
            count = $urandom_range(1, 2) * active_width() * active_height();
            split = ($urandom_range(3) == 0) ? $urandom_range(1, count - 1) : count;
        end
        repeat (split) send_pixel(next_pixel(), 1'b0, '0);
        if (split < count)
        begin
            // a narrower row is only safe once every kept column holds two written lines
            new_w = $urandom_range(3, active_width());
            safe  = 1'b1;
            for (int c = 0; c < new_w; c++)
                if (col_writes[c] < 2)
                    safe = 1'b0;
            if (idx != 3 && safe && $urandom_range(1))
                write_reg(scharr_pkg::REG_IMAGE_WIDTH, 12'(new_w));
            else
                write_reg(scharr_pkg::REG_IMAGE_HEIGHT, 12'($urandom_range(8)));
            repeat (count - split) send_pixel(next_pixel(), 1'b0, '0);
        end
        // the directed frames have written the first three columns twice
        if (idx == 1 || idx == 4)
            write_reg(scharr_pkg::REG_IMAGE_WIDTH, 12'd3);
        while (row_pos != 0 || col_pos != 0)
            send_pixel(next_pixel(), 1'b0, '0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
            res_bus.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        grad_word_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_gradients.size() == 0)
                note_failure($sformatf("result word with nothing expected: row %0d col %0d",
                                       res_bus.center_row, res_bus.center_col));
            else
            begin
                want = pending_gradients.pop_front();
                report_field("grad_x", res_bus.grad_x, want.grad_x);
                report_field("grad_y", res_bus.grad_y, want.grad_y);
                report_field("center_row", res_bus.center_row, want.center_row);
                report_field("center_col", 12'(res_bus.center_col), 12'(want.center_col));
                report_field("last_of_frame", 12'(res_bus.last_of_frame),
                             12'(want.last_of_frame));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned waited;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= scharr_pkg::REG_IMAGE_WIDTH;
        cfg_data      <= '0;
        pix_bus.valid <= 1'b0;
        pix_bus.pixel <= '0;
        no_gaps       <= 1'b0;
        prev_pixel    = 8'd128;

        // 3x3 frames: a full left-to-right step, then a full top-to-bottom step
        // under out-of-range sizes that act as 3x3
        directed_rows = '{
            cfg_row(scharr_pkg::REG_IMAGE_WIDTH, 12'd3),
            cfg_row(scharr_pkg::REG_IMAGE_HEIGHT, 12'd3),
            pix_row(8'd0), pix_row(8'd128), pix_row(8'd255),
            pix_row(8'd0), pix_row(8'd128), pix_row(8'd255),
            pix_row(8'd0), pix_row(8'd128),
            checked_pix_row(8'd255, '{12'd4080, 12'd0, 12'd1, 10'd1, 1'b1}),
            cfg_row(scharr_pkg::REG_IMAGE_WIDTH, 12'd2),
            cfg_row(scharr_pkg::REG_IMAGE_HEIGHT, 12'd1),
            pix_row(8'd255), pix_row(8'd255), pix_row(8'd255),
            pix_row(8'd9), pix_row(8'd9), pix_row(8'd9),
            pix_row(8'd0), pix_row(8'd0),
            checked_pix_row(8'd0, '{12'd0, 12'd4080, 12'd1, 10'd1, 1'b1})
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            else
                send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                           directed_rows[i].word);
        end

        phase = 0;
        while (phase < 6 || fed_pixels < RANDOM_PIXELS)
        begin
            run_phase(phase);
            phase++;
        end

        pix_bus.valid <= 1'b0;
        waited = 0;
        while (pending_gradients.size() != 0 && waited < END_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += pending_gradients.size();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
